FILE: hw/rtl/frx_pkg.sv
// Package for the frame receiver register map.
// Holds the sizes, the header and length limits, the access codes and the event codes.
// Depends on nothing.
package frx_pkg;

  localparam int RegCount  = 32;
  localparam int MaxFrame  = 44;
  localparam int MinFrame  = 8;
  localparam int RegAddrW  = (RegCount > 1) ? $clog2(RegCount) : 1;

  localparam logic [7:0] HeaderByte = 8'hAA;

  // Byte positions inside a frame: header 0, length 1, address 2, data 3 to 6.
  localparam logic [5:0] IdxLen      = 6'd1;
  localparam logic [5:0] IdxAddr     = 6'd2;
  localparam logic [5:0] IdxDataLow  = 6'd3;
  localparam logic [5:0] IdxDataHigh = 6'd6;

  typedef enum logic [1:0] {
    ActByte  = 2'd0,
    ActRead  = 2'd1,
    ActQuery = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvWritten = 3'd1,
    EvSumBad  = 3'd2,
    EvLenBad  = 3'd3,
    EvAddrBad = 3'd4
  } event_e;

endpackage

FILE: hw/rtl/frame_receiver_register_map.sv
// Frame receiver with a register map: byte parser, register file, new-data flags.
// Depends on frx_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | action_i, rx_byte_i, reg_addr_i
//  out     | output    | out_valid_o / out_stall_i | read_word_o, new_flag_o,
//          |           |                           | frame_event_o, event_addr_o
//
// One beat is accepted and one result is produced per cycle while the output is not stalled.
// A beat is captured in the input register and handled once the result register is free:
// the parser step and the register file access lie between the input and result
// registers, and the outcome is loaded into the result register, from which it is taken.
// Reset clears the parser, the whole register file and every new-data flag at once, so
// no clearing pass is needed and beats are taken from the first cycle after reset.
// A stall on the output holds the result register; the input register keeps accepting
// until it too is full, and only then is in_stall_o raised.
module frame_receiver_register_map
  import frx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  reg_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_word_o,
  output logic        new_flag_o,
  output logic [2:0]  frame_event_o,
  output logic [7:0]  event_addr_o
);

  typedef enum logic [1:0] {
    PhHunt,
    PhLen,
    PhAddr,
    PhBody
  } phase_e;

  // Input register.
  logic       in_full_q;
  logic [1:0] action_q;
  logic [7:0] rx_byte_q;
  logic [7:0] reg_addr_q;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [5:0]  byte_index_q, byte_index_d;
  logic [5:0]  frame_length_q, frame_length_d;
  logic [7:0]  frame_addr_q, frame_addr_d;
  logic [31:0] data_word_q, data_word_d;
  logic [7:0]  running_sum_q, running_sum_d;

  // Register file and new-data flags, cleared by reset.
  logic [31:0] regs_q [RegCount];
  logic [RegCount-1:0] fresh_q;

  // Result register.
  logic        out_full_q;
  logic [31:0] read_word_q, read_word_d;
  logic        new_flag_q, new_flag_d;
  logic [2:0]  frame_event_q, frame_event_d;
  logic [7:0]  event_addr_q, event_addr_d;

  logic                out_free;
  logic                fire;
  logic                reg_wr;
  logic                flag_clr;
  logic [RegAddrW-1:0] wr_idx;
  logic [RegAddrW-1:0] rd_idx;
  logic                rd_in_range;
  logic                frame_in_range;
  logic [6:0]          next_pos;
  logic [1:0]          lane;

  // The result register is free when it is empty or is being drained this cycle.
  assign out_free   = !out_full_q || !out_stall_i;
  assign fire       = in_full_q && out_free;
  assign in_stall_o = in_full_q && !out_free;

  assign rd_in_range    = {1'b0, reg_addr_q} < 9'(RegCount);
  assign frame_in_range = {1'b0, frame_addr_q} < 9'(RegCount);
  assign rd_idx         = rd_in_range ? reg_addr_q[RegAddrW-1:0] : '0;
  assign wr_idx         = frame_addr_q[RegAddrW-1:0];
  assign next_pos       = {1'b0, byte_index_q} + 7'd1;
  assign lane           = 2'(byte_index_q - IdxDataLow);

  always_comb begin
    phase_d        = phase_q;
    byte_index_d   = byte_index_q;
    frame_length_d = frame_length_q;
    frame_addr_d   = frame_addr_q;
    data_word_d    = data_word_q;
    running_sum_d  = running_sum_q;
    read_word_d    = '0;
    new_flag_d     = 1'b0;
    frame_event_d  = EvNone;
    event_addr_d   = '0;
    reg_wr         = 1'b0;
    flag_clr       = 1'b0;

    case (action_q)
      ActByte: begin
        unique case (phase_q)
          PhHunt: begin
            if (rx_byte_q == HeaderByte) begin
              phase_d       = PhLen;
              byte_index_d  = IdxLen;
              data_word_d   = '0;
              running_sum_d = '0;
              frame_addr_d  = '0;
            end
          end
          PhLen: begin
            if (rx_byte_q < 8'(MinFrame) || rx_byte_q > 8'(MaxFrame)) begin
              frame_event_d = EvLenBad;
              phase_d       = PhHunt;
              byte_index_d  = '0;
            end else begin
              frame_length_d = rx_byte_q[5:0];
              running_sum_d  = rx_byte_q;
              byte_index_d   = IdxAddr;
              phase_d        = PhAddr;
            end
          end
          PhAddr: begin
            frame_addr_d  = rx_byte_q;
            running_sum_d = running_sum_q + rx_byte_q;
            byte_index_d  = IdxDataLow;
            phase_d       = PhBody;
          end
          PhBody: begin
            if (next_pos >= {1'b0, frame_length_q}) begin
              // Checksum byte closes the frame whatever its outcome.
              if (rx_byte_q != running_sum_q) begin
                frame_event_d = EvSumBad;
              end else if (frame_in_range) begin
                reg_wr        = 1'b1;
                frame_event_d = EvWritten;
              end else begin
                frame_event_d = EvAddrBad;
              end
              event_addr_d = frame_addr_q;
              phase_d      = PhHunt;
              byte_index_d = '0;
            end else begin
              if (byte_index_q >= IdxDataLow && byte_index_q <= IdxDataHigh) begin
                data_word_d[8*lane +: 8] = rx_byte_q;
                if (byte_index_q == IdxDataLow) begin
                  running_sum_d = running_sum_q + rx_byte_q;
                end
              end
              byte_index_d = next_pos[5:0];
            end
          end
          default: begin
            phase_d      = PhHunt;
            byte_index_d = '0;
          end
        endcase
      end
      ActRead: begin
        read_word_d = regs_q[rd_idx];
        new_flag_d  = rd_in_range && fresh_q[rd_idx];
        flag_clr    = rd_in_range;
      end
      ActQuery: begin
        new_flag_d = rd_in_range && fresh_q[rd_idx];
      end
      default: begin
        // Unused code: no state change and an all-zero result.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q      <= 1'b0;
      out_full_q     <= 1'b0;
      phase_q        <= PhHunt;
      byte_index_q   <= '0;
      frame_length_q <= '0;
      frame_addr_q   <= '0;
      data_word_q    <= '0;
      running_sum_q  <= '0;
      fresh_q        <= '0;
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      if (!in_stall_o) begin
        in_full_q <= in_valid_i;
      end
      if (out_free) begin
        out_full_q <= fire;
      end
      if (fire) begin
        phase_q        <= phase_d;
        byte_index_q   <= byte_index_d;
        frame_length_q <= frame_length_d;
        frame_addr_q   <= frame_addr_d;
        data_word_q    <= data_word_d;
        running_sum_q  <= running_sum_d;
        if (reg_wr) begin
          regs_q[wr_idx]  <= data_word_q;
          fresh_q[wr_idx] <= 1'b1;
        end
        if (flag_clr) begin
          fresh_q[rd_idx] <= 1'b0;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q   <= action_i;
      rx_byte_q  <= rx_byte_i;
      reg_addr_q <= reg_addr_i;
    end
    if (fire) begin
      read_word_q   <= read_word_d;
      new_flag_q    <= new_flag_d;
      frame_event_q <= frame_event_d;
      event_addr_q  <= event_addr_d;
    end
  end

  assign out_valid_o   = out_full_q;
  assign read_word_o   = read_word_q;
  assign new_flag_o    = new_flag_q;
  assign frame_event_o = frame_event_q;
  assign event_addr_o  = event_addr_q;

endmodule

FILE: hw/rtl/frx_checker.sv
// Port-level checks for the frame receiver register map, bound to the top level.
// Depends on frx_pkg.
module frx_checker
  import frx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_word_o,
  input logic        new_flag_o,
  input logic [2:0]  frame_event_o,
  input logic [7:0]  event_addr_o
);

  // A result that is stalled stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_word_o) &&
      $stable(new_flag_o) && $stable(frame_event_o) && $stable(event_addr_o))
    else $error("stalled result changed");

  // The input side only stalls when the result register is full and held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // An accepted beat is expected to show up as a result on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted beat produced no result");

  // A frame event comes from a byte beat, which reads no register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_event_o != EvNone) |-> (read_word_o == '0) && !new_flag_o)
    else $error("frame event combined with register data");

  // No address accompanies a result with no frame event or with a rejected length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_event_o == EvNone || frame_event_o == EvLenBad)
      |-> event_addr_o == '0)
    else $error("event address without a completed frame");

endmodule

bind frame_receiver_register_map frx_checker u_frx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .read_word_o   (read_word_o),
  .new_flag_o    (new_flag_o),
  .frame_event_o (frame_event_o),
  .event_addr_o  (event_addr_o)
);

FILE: test/frame_receiver_register_map_tb.sv
// Testbench for frame_receiver_register_map: directed and random beats through the
// byte parser and register map, each response checked against an in-bench model.
// Depends on frx_pkg and the frame_receiver_register_map RTL.
module frame_receiver_register_map_tb;
  import frx_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int IdleLimit = 1000;
  localparam int HoldCycles = 80;
  localparam int TotalBeats = 500;

  typedef struct packed {
    logic [31:0] word;
    logic        flag;
    logic [2:0]  event_code;
    logic [7:0]  frame_addr;
  } response_t;

  typedef enum logic [1:0] {Hunt, TakeLen, TakeAddr, TakeBody} parse_phase_e;
  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallToggle} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = ActByte;
  logic [7:0]  rx_byte_i = 8'h00;
  logic [7:0]  reg_addr_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_word_o;
  logic        new_flag_o;
  logic [2:0]  frame_event_o;
  logic [7:0]  event_addr_o;

  frame_receiver_register_map dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .action_i, .rx_byte_i, .reg_addr_i,
    .out_valid_o, .out_stall_i, .read_word_o, .new_flag_o, .frame_event_o, .event_addr_o
  );

  // Shadow copy of the parser and register map.
  parse_phase_e parse_phase = Hunt;
  logic [5:0]   byte_pos = '0;
  logic [5:0]   len_acc = '0;
  logic [7:0]   addr_acc = '0;
  logic [31:0]  word_acc = '0;
  logic [7:0]   sum_acc = '0;
  logic [31:0]  shadow_regs [RegCount];
  logic         shadow_flags [RegCount];

  response_t responses_due [$];
  int bad_responses = 0;
  int beats_sent = 0;
  int idle_cycles = 0;

  bit gaps_enabled = 1'b1;
  int burst_left = 0;

  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  stall_mode_e stall_mode = StallNone;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic response_t compute_response(input logic [1:0] act, input logic [7:0] rx,
                                                 input logic [7:0] addr);
    response_t r;
    r = '0;
    if (act == ActByte) begin
      case (parse_phase)
        Hunt: begin
          if (rx == HeaderByte) begin
            parse_phase = TakeLen;
            byte_pos = IdxLen;
            word_acc = '0;
            sum_acc = '0;
            addr_acc = '0;
          end
        end
        TakeLen: begin
          if (rx < MinFrame || rx > MaxFrame) begin
            r.event_code = EvLenBad;
            parse_phase = Hunt;
            byte_pos = '0;
          end else begin
            len_acc = rx[5:0];
            sum_acc = rx;
            byte_pos = IdxAddr;
            parse_phase = TakeAddr;
          end
        end
        TakeAddr: begin
          addr_acc = rx;
          sum_acc = sum_acc + rx;
          byte_pos = IdxDataLow;
          parse_phase = TakeBody;
        end
        default: begin
          if ({1'b0, byte_pos} + 7'd1 >= {1'b0, len_acc}) begin
            // Last byte of the frame carries the checksum.
            if (rx != sum_acc) begin
              r.event_code = EvSumBad;
            end else if (addr_acc < RegCount) begin
              shadow_regs[addr_acc[RegAddrW-1:0]] = word_acc;
              shadow_flags[addr_acc[RegAddrW-1:0]] = 1'b1;
              r.event_code = EvWritten;
            end else begin
              r.event_code = EvAddrBad;
            end
            r.frame_addr = addr_acc;
            parse_phase = Hunt;
            byte_pos = '0;
          end else begin
            if (byte_pos >= IdxDataLow && byte_pos <= IdxDataHigh) begin
              word_acc[(byte_pos - IdxDataLow) * 8 +: 8] = rx;
              if (byte_pos == IdxDataLow) sum_acc = sum_acc + rx;
            end
            byte_pos = byte_pos + 6'd1;
          end
        end
      endcase
    end else if (act == ActRead) begin
      if (addr < RegCount) begin
        r.word = shadow_regs[addr[RegAddrW-1:0]];
        r.flag = shadow_flags[addr[RegAddrW-1:0]];
        shadow_flags[addr[RegAddrW-1:0]] = 1'b0;
      end else begin
        r.word = shadow_regs[0];
      end
    end else if (act == ActQuery) begin
      if (addr < RegCount) r.flag = shadow_flags[addr[RegAddrW-1:0]];
    end
    return r;
  endfunction

  // Offers one beat, holds it until taken, then maybe leaves a gap before the next.
  task automatic send_beat(input logic [1:0] act, input logic [7:0] rx, input logic [7:0] addr);
    in_valid_i <= 1'b1;
    action_i <= act;
    rx_byte_i <= rx;
    reg_addr_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    responses_due.push_back(compute_response(act, rx, addr));
    beats_sent++;
    if (gaps_enabled) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(0, 30);
      end
    end
  endtask

  task automatic send_access();
    logic [7:0] a;
    a = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'($urandom_range(0, RegCount - 1));
    send_beat(($urandom_range(0, 1) == 0) ? ActRead : ActQuery, 8'($urandom), a);
  endtask

  // Sends a whole frame with random padding; optionally slips accesses in between bytes.
  task automatic send_frame(input int unsigned len, input logic [7:0] addr,
                            input logic [31:0] word, input bit sum_ok, input bit mix_access);
    logic [55:0] lead;
    logic [7:0]  chk;
    logic [7:0]  frame_bytes [$];
    lead = {word, addr, 8'(len), HeaderByte};
    chk = 8'(len) + addr + word[7:0];
    if (!sum_ok) chk = chk ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 7; i++) frame_bytes.push_back(lead[8 * i +: 8]);
    for (int i = 8; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(chk);
    foreach (frame_bytes[i]) begin
      if (mix_access && $urandom_range(0, 9) == 0) send_access();
      send_beat(ActByte, frame_bytes[i], 8'($urandom));
    end
  endtask

  task automatic test_unused_and_range();
    send_beat(ActUnused, 8'hFF, 8'hFF);
    send_beat(ActRead, 8'h00, 8'hFF);
    send_beat(ActQuery, 8'h00, 8'(RegCount));
    send_beat(ActRead, 8'h00, 8'h00);
  endtask

  task automatic test_bad_length();
    // A rejected length byte equal to the header must not start a new frame.
    send_beat(ActByte, HeaderByte, 8'h00);
    send_beat(ActByte, HeaderByte, 8'h00);
    send_beat(ActByte, HeaderByte, 8'h00);
    send_beat(ActByte, 8'(MinFrame - 1), 8'h00);
    send_beat(ActByte, HeaderByte, 8'h00);
    send_beat(ActByte, 8'(MaxFrame + 1), 8'h00);
  endtask

  task automatic test_frame_write();
    // Header value as data, and a query between the address and data bytes.
    send_beat(ActByte, HeaderByte, 8'h00);
    send_beat(ActByte, 8'd8, 8'h00);
    send_beat(ActByte, 8'h1F, 8'h00);
    send_beat(ActQuery, 8'h00, 8'h1F);
    send_beat(ActByte, HeaderByte, 8'h00);
    send_beat(ActByte, 8'hFF, 8'h00);
    send_beat(ActByte, 8'h00, 8'h00);
    send_beat(ActByte, 8'h80, 8'h00);
    send_beat(ActByte, 8'd8 + 8'h1F + HeaderByte, 8'h00);
    send_beat(ActRead, 8'h00, 8'h1F);
    send_beat(ActQuery, 8'h00, 8'h1F);
  endtask

  task automatic test_bad_frames();
    send_frame(8, 8'hFF, 32'h0, 1'b0, 1'b0);
    send_frame(9, 8'(RegCount), 32'h4433_2211, 1'b1, 1'b0);
  endtask

  task automatic test_back_pressure();
    gaps_enabled = 1'b0;
    holds_asked++;
    repeat (40) send_access();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_traffic();
    int pick;
    int unsigned len;
    logic [7:0] addr;
    while (beats_sent < TotalBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0: len = MaxFrame;
          1: len = $urandom_range(MinFrame, MaxFrame);
          default: len = $urandom_range(MinFrame, MinFrame + 4);
        endcase
        addr = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, RegCount - 1));
        send_frame(len, addr, $urandom, $urandom_range(0, 7) != 0, 1'b1);
      end else if (pick < 85) begin
        send_access();
      end else if (pick < 92) begin
        send_beat(ActByte, 8'($urandom_range(0, 255)), 8'($urandom));
      end else if (pick < 97) begin
        send_beat(ActByte, HeaderByte, 8'($urandom));
        send_beat(ActByte, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, MinFrame - 1))
                                                       : 8'($urandom_range(MaxFrame + 1, 255)),
                  8'($urandom));
      end else begin
        send_beat(ActUnused, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin : receiver_stall
    if (rst_ni) begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : response_check
    response_t got;
    response_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{read_word_o, new_flag_o, frame_event_o, event_addr_o};
      if (responses_due.size() == 0) begin
        bad_responses++;
        if (bad_responses <= 10)
          $display("unexpected response: word %h flag %b event %0d addr %h",
                   got.word, got.flag, got.event_code, got.frame_addr);
      end else begin
        want = responses_due.pop_front();
        if (got.word !== want.word || got.flag !== want.flag
            || got.event_code !== want.event_code || got.frame_addr !== want.frame_addr) begin
          bad_responses++;
          if (bad_responses <= 10)
            $display("mismatch: expected word %h flag %b event %0d addr %h,",
                     want.word, want.flag, want.event_code, want.frame_addr,
                     " got word %h flag %b event %0d addr %h",
                     got.word, got.flag, got.event_code, got.frame_addr);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no beat moved for %0d cycles", IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < RegCount; i++) begin
      shadow_regs[i] = '0;
      shadow_flags[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unused_and_range();
    test_bad_length();
    test_frame_write();
    test_bad_frames();
    test_back_pressure();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (bad_responses == 0 && responses_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
